FILE: design/s2lch_pkg.sv
// Shared types, constants and tables for the sRGB to CIE LCh pixel pipeline.
package s2lch_pkg;

    localparam int ChN       = 3;
    localparam int CodeW     = 8;
    localparam int LinW      = 21;
    localparam int CoefW     = 27;
    localparam int ProdW     = 48;
    localparam int RecipW    = 26;
    localparam int EstW      = (ProdW - 20) + RecipW;
    localparam int QW        = 22;
    localparam int RemW      = QW + CoefW;
    localparam int VW        = 21;
    localparam int FW        = 22;
    localparam int CbrtSteps = FW;
    localparam int SqW       = 24;
    localparam int CubeW     = 26;
    localparam int LinNW     = 27;
    localparam int LinPW     = 55;
    localparam int LW        = 31;
    localparam int OutLW     = 15;
    localparam int OutCW     = 16;
    localparam int OutHW     = 16;
    localparam int AW        = 32;
    localparam int XW        = 35;
    localparam int ZW        = 20;
    localparam int SqrtSteps = 32;
    localparam int SqrtRemW  = 35;
    localparam int SqrtInW   = 64;
    localparam int CordicN   = 16;
    localparam int LabFLat   = 2 * CbrtSteps + 3;
    localparam int Latency   = 6 + LabFLat + 3 + SqrtSteps + 1;

    localparam logic [VW-1:0]    LinCut   = 21'd9286;
    localparam logic [LinPW-1:0] Recip1k  = 55'd137438954;
    localparam logic [FW-1:0]    FOffset  = 22'd144631;
    localparam logic [OutLW-1:0] LMax     = 15'd25600;
    localparam logic signed [ZW-1:0] PiQ16 = 20'sd205887;
    localparam logic signed [ZW-1:0] PiQ13 = 20'sd25736;

    typedef logic [CodeW-1:0] t_code;
    typedef logic [LinW-1:0]  t_lin;
    typedef logic [VW-1:0]    t_v;
    typedef logic [FW-1:0]    t_f;
    typedef logic [255:0][LinW-1:0] t_lin_tab;

    localparam logic [CoefW-1:0] Mat [ChN][ChN] = '{
        '{27'd41239080, 27'd35758434, 27'd18048079},
        '{27'd21263901, 27'd71516868, 27'd7219232},
        '{27'd1933082,  27'd11919478, 27'd95053215}
    };

    localparam logic [CoefW-1:0] WhiteDiv [ChN] = '{
        27'd95048900, 27'd100000000, 27'd108884000
    };

    localparam logic [RecipW-1:0] Recip [ChN] = '{
        26'((64'd1 << 52) / 64'd95048900),
        26'((64'd1 << 52) / 64'd100000000),
        26'((64'd1 << 52) / 64'd108884000)
    };

    localparam logic signed [ZW-1:0] AtanTab [CordicN] = '{
        20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
        20'sd16, 20'sd8, 20'sd4, 20'sd2
    };

    function automatic logic [63:0] pow5_q30(input logic [63:0] r);
        logic [63:0] p2;
        logic [63:0] p4;
        logic [63:0] p5;
        p2 = (r * r) >> 30;
        p4 = (p2 * p2) >> 30;
        p5 = (p4 * r) >> 30;
        return p5;
    endfunction

    // sRGB decode curve per 8-bit code, Q.20
    function automatic t_lin_tab build_lin_tab();
        t_lin_tab    tab;
        logic [63:0] c;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] lin;
        for (int i = 0; i < 256; i++) begin
            c = 64'(i);
            if (c * 64'd100000 <= 64'd1031475) begin
                lin = (c * 64'd104857600 + 64'd164730) / 64'd329460;
            end else begin
                t = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
                s = (t * t) >> 30;
                r = '0;
                for (int b = 30; b >= 0; b--) begin
                    cand = r | (64'd1 << b);
                    if (cand <= (64'd1 << 30) && pow5_q30(cand) <= s) begin
                        r = cand;
                    end
                end
                lin = (((s * r) >> 30) + 64'd512) >> 10;
            end
            tab[i] = lin[LinW-1:0];
        end
        return tab;
    endfunction

    localparam t_lin_tab LinTab = build_lin_tab();

endpackage

FILE: design/srgb_to_lch_pixel_core.sv
// Top level: 8-bit sRGB pixel to CIE LCh (D65) fixed-point pipeline.
//
// Input: drive i_red_channel, i_green_channel, i_blue_channel with i_start.
// A pixel is taken at each rising edge where i_start is high and o_busy is
// low. o_busy stays low, so one pixel may enter on every clock.
// Output: o_done is high for exactly one cycle with o_lightness (L* x256),
// o_chroma (Q8.8, saturating) and o_hue_angle (radians x8192, signed).
// The receiver cannot hold results off; each one is gone after its cycle.
// Throughput is one pixel per cycle. The pipeline depth is set by the cube
// root (two stages per root bit, 22 bits) and the 32-step square root for
// chroma, which runs alongside the 16-step CORDIC for hue.
// Pixels are independent; nothing is held between them.
// Reset (i_rst_n low at a clock edge) clears all valid bits, dropping every
// pixel in flight; data registers are not cleared.
module srgb_to_lch_pixel_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  s2lch_pkg::t_code         i_red_channel,
    input  s2lch_pkg::t_code         i_green_channel,
    input  s2lch_pkg::t_code         i_blue_channel,
    output logic                     o_done,
    output logic [14:0]              o_lightness,
    output logic [15:0]              o_chroma,
    output logic signed [15:0]       o_hue_angle
);
    import s2lch_pkg::*;

    assign o_busy = 1'b0;

    // ---------------- decode, matrix, white-point divide ----------------
    logic             r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_lin             r_lin  [ChN];
    logic [ProdW-1:0] r_prod [ChN][ChN];
    logic [ProdW-1:0] r_sum  [ChN];
    logic [ProdW-1:0] r_n4   [ChN];
    logic [ProdW-1:0] r_n5   [ChN];
    logic [EstW-1:0]  r_est  [ChN];
    logic [QW-1:0]    r_qe   [ChN];
    logic [RemW-1:0]  r_qd   [ChN];
    t_v               r_xyz  [ChN];
    logic [RemW-1:0]  w_rem  [ChN];
    logic [QW-1:0]    w_q    [ChN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_start && !o_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_comb begin
        for (int i = 0; i < ChN; i++) begin
            w_rem[i] = RemW'(r_n5[i]) - r_qd[i];
            w_q[i]   = r_qe[i] + QW'(w_rem[i] >= RemW'(WhiteDiv[i]));
        end
    end

    // quotient estimate is low by at most one; the remainder check fixes it
    always_ff @(posedge i_clk) begin
        r_lin[0] <= LinTab[i_red_channel];
        r_lin[1] <= LinTab[i_green_channel];
        r_lin[2] <= LinTab[i_blue_channel];
        for (int i = 0; i < ChN; i++) begin
            for (int j = 0; j < ChN; j++) begin
                r_prod[i][j] <= ProdW'(r_lin[j]) * ProdW'(Mat[i][j]);
            end
            r_sum[i] <= r_prod[i][0] + r_prod[i][1] + r_prod[i][2]
                      + ProdW'(WhiteDiv[i] >> 1);
            r_n4[i]  <= r_sum[i];
            r_est[i] <= EstW'(r_sum[i][ProdW-1:20]) * EstW'(Recip[i]);
            r_n5[i]  <= r_n4[i];
            r_qe[i]  <= r_est[i][EstW-1:32];
            r_qd[i]  <= RemW'(r_est[i][EstW-1:32]) * RemW'(WhiteDiv[i]);
            r_xyz[i] <= w_q[i][VW-1:0];
        end
    end

    // ---------------- f(t) ----------------
    logic w_fval;
    t_f   w_f [ChN];

    s2lch_lab_f u_lab_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_v     (r_xyz),
        .o_valid (w_fval),
        .o_f     (w_f)
    );

    // ---------------- L, a, b ----------------
    logic signed [FW:0]   w_dx, w_dz;
    logic signed [LW-1:0] w_lt;
    logic [OutLW-1:0]     w_l;
    logic                 r_vp;
    logic signed [AW-1:0] r_a, r_b;
    logic [OutLW-1:0]     r_lp;

    assign w_dx = $signed({1'b0, w_f[0]}) - $signed({1'b0, w_f[1]});
    assign w_dz = $signed({1'b0, w_f[1]}) - $signed({1'b0, w_f[2]});
    assign w_lt = ($signed(LW'(w_f[1])) * LW'(116) - LW'(16 << 20) + LW'(2048)) >>> 12;

    always_comb begin
        if (w_lt < 0) begin
            w_l = '0;
        end else if (w_lt > LW'(LMax)) begin
            w_l = LMax;
        end else begin
            w_l = w_lt[OutLW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= AW'(w_dx) * AW'(500);
        r_b  <= AW'(w_dz) * AW'(200);
        r_lp <= w_l;
    end

    // ---------------- squares and CORDIC pre-rotation ----------------
    logic                 r_vq;
    logic [SqrtInW-1:0]   r_sqa, r_sqb;
    logic signed [XW-1:0] r_qx, r_qy;
    logic signed [ZW-1:0] r_qz;
    logic                 r_qzero;
    logic [OutLW-1:0]     r_ql;
    logic [AW-1:0]        w_ua, w_ub;

    assign w_ua = r_a[AW-1] ? AW'(-r_a) : AW'(r_a);
    assign w_ub = r_b[AW-1] ? AW'(-r_b) : AW'(r_b);

    always_ff @(posedge i_clk) begin
        r_sqa   <= SqrtInW'(w_ua) * SqrtInW'(w_ua);
        r_sqb   <= SqrtInW'(w_ub) * SqrtInW'(w_ub);
        r_qzero <= (r_a == '0) && (r_b == '0);
        r_ql    <= r_lp;
        if (r_a < 0) begin
            r_qx <= -XW'(r_a);
            r_qy <= -XW'(r_b);
            r_qz <= (r_b >= 0) ? PiQ16 : -PiQ16;
        end else begin
            r_qx <= XW'(r_a);
            r_qy <= XW'(r_b);
            r_qz <= '0;
        end
    end

    // ---------------- square root and CORDIC ----------------
    logic                  r_sv    [SqrtSteps+1];
    logic [SqrtInW-1:0]    r_sn    [SqrtSteps+1];
    logic [SqrtRemW-1:0]   r_srem  [SqrtSteps+1];
    logic [SqrtSteps-1:0]  r_sroot [SqrtSteps+1];
    logic signed [XW-1:0]  r_cx    [CordicN+1];
    logic signed [XW-1:0]  r_cy    [CordicN+1];
    logic signed [ZW-1:0]  r_cz    [SqrtSteps+1];
    logic                  r_czero [SqrtSteps+1];
    logic [OutLW-1:0]      r_cl    [SqrtSteps+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp     <= 1'b0;
            r_vq     <= 1'b0;
            r_sv[0]  <= 1'b0;
        end else begin
            r_vp     <= w_fval;
            r_vq     <= r_vp;
            r_sv[0]  <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sn[0]    <= r_sqa + r_sqb;
        r_srem[0]  <= '0;
        r_sroot[0] <= '0;
        r_cx[0]    <= r_qx;
        r_cy[0]    <= r_qy;
        r_cz[0]    <= r_qz;
        r_czero[0] <= r_qzero;
        r_cl[0]    <= r_ql;
    end

    for (genvar j = 0; j < SqrtSteps; j++) begin : g_iter
        logic [SqrtRemW+1:0] w_rem2;
        logic [SqrtRemW+1:0] w_trial;

        assign w_rem2  = {r_srem[j], r_sn[j][SqrtInW-1 -: 2]};
        assign w_trial = (SqrtRemW+2)'({r_sroot[j], 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sn[j+1]    <= r_sn[j] << 2;
            r_czero[j+1] <= r_czero[j];
            r_cl[j+1]    <= r_cl[j];
            if (w_rem2 >= w_trial) begin
                r_srem[j+1]  <= SqrtRemW'(w_rem2 - w_trial);
                r_sroot[j+1] <= {r_sroot[j][SqrtSteps-2:0], 1'b1};
            end else begin
                r_srem[j+1]  <= SqrtRemW'(w_rem2);
                r_sroot[j+1] <= {r_sroot[j][SqrtSteps-2:0], 1'b0};
            end
        end

        if (j < CordicN) begin : g_rot
            logic signed [XW-1:0] w_xs, w_ys;
            assign w_xs = r_cx[j] >>> j;
            assign w_ys = r_cy[j] >>> j;

            always_ff @(posedge i_clk) begin
                if (r_cy[j] >= 0) begin
                    r_cx[j+1] <= r_cx[j] + w_ys;
                    r_cy[j+1] <= r_cy[j] - w_xs;
                    r_cz[j+1] <= r_cz[j] + AtanTab[j];
                end else begin
                    r_cx[j+1] <= r_cx[j] - w_ys;
                    r_cy[j+1] <= r_cy[j] + w_xs;
                    r_cz[j+1] <= r_cz[j] - AtanTab[j];
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                r_cz[j+1] <= r_cz[j];
            end
        end
    end

    // ---------------- rounding and output register ----------------
    logic [SqrtSteps:0]   w_csum;
    logic [OutCW-1:0]     w_c;
    logic signed [ZW-1:0] w_h;
    logic [OutHW-1:0]     w_hue;
    logic                 r_done;
    logic [OutLW-1:0]     r_lightness;
    logic [OutCW-1:0]     r_chroma;
    logic [OutHW-1:0]     r_hue;

    assign w_csum = (SqrtSteps+1)'(r_sroot[SqrtSteps]) + (SqrtSteps+1)'(2048);
    assign w_c    = (w_csum[SqrtSteps:12] > (SqrtSteps-11)'(16'hFFFF)) ? 16'hFFFF
                                                                        : w_csum[27:12];
    assign w_h    = (r_cz[SqrtSteps] + ZW'(4)) >>> 3;

    always_comb begin
        if (r_czero[SqrtSteps]) begin
            w_hue = '0;
        end else if (w_h > PiQ13) begin
            w_hue = OutHW'(PiQ13);
        end else if (w_h < -PiQ13) begin
            w_hue = OutHW'(-PiQ13);
        end else begin
            w_hue = w_h[OutHW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_sv[SqrtSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lightness <= r_cl[SqrtSteps];
        r_chroma    <= w_c;
        r_hue       <= w_hue;
    end

    assign o_done      = r_done;
    assign o_lightness = r_lightness;
    assign o_chroma    = r_chroma;
    assign o_hue_angle = $signed(r_hue);

    // ---------------- assertions ----------------
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##Latency o_done)
        else $error("pixel did not come out after the pipeline latency");

    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, Latency))
        else $error("result without a matching input beat");

    a_l_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_lightness <= LMax))
        else $error("lightness out of range");

    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hue_angle <= 16'sd25736 && o_hue_angle >= -16'sd25736))
        else $error("hue out of range");

endmodule

FILE: design/s2lch_lab_f.sv
// CIELAB f function on three channels: pipelined cube root with linear segment.
module s2lch_lab_f (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  s2lch_pkg::t_v    i_v [s2lch_pkg::ChN],
    output logic             o_valid,
    output s2lch_pkg::t_f    o_f [s2lch_pkg::ChN]
);
    import s2lch_pkg::*;

    localparam int SqProdW   = 2 * FW;
    localparam int CubeProdW = SqW + FW;

    logic           r_aval  [CbrtSteps];
    logic [SqW-1:0] r_asq   [CbrtSteps][ChN];
    t_f             r_aroot [CbrtSteps][ChN];
    t_v             r_av    [CbrtSteps][ChN];
    logic           r_bval  [CbrtSteps];
    t_f             r_broot [CbrtSteps][ChN];
    t_v             r_bv    [CbrtSteps][ChN];

    logic w_val  [CbrtSteps+1];
    t_v   w_v    [CbrtSteps+1][ChN];
    t_f   w_root [CbrtSteps+1][ChN];

    always_comb begin
        w_val[0] = i_valid;
        for (int ch = 0; ch < ChN; ch++) begin
            w_v[0][ch]    = i_v[ch];
            w_root[0][ch] = '0;
        end
        for (int s = 0; s < CbrtSteps; s++) begin
            w_val[s+1] = r_bval[s];
            for (int ch = 0; ch < ChN; ch++) begin
                w_v[s+1][ch]    = r_bv[s][ch];
                w_root[s+1][ch] = r_broot[s][ch];
            end
        end
    end

    // one root bit per step: square, then cube and compare
    for (genvar s = 0; s < CbrtSteps; s++) begin : g_step
        localparam int Bit = FW - 1 - s;
        t_f               w_ca   [ChN];
        t_f               w_cb   [ChN];
        logic [SqW-1:0]   w_sq   [ChN];
        logic [CubeW-1:0] w_cube [ChN];

        always_comb begin
            for (int ch = 0; ch < ChN; ch++) begin
                w_ca[ch]   = w_root[s][ch] | (FW'(1) << Bit);
                w_sq[ch]   = SqW'((SqProdW'(w_ca[ch]) * SqProdW'(w_ca[ch])) >> 20);
                w_cb[ch]   = r_aroot[s][ch] | (FW'(1) << Bit);
                w_cube[ch] = CubeW'((CubeProdW'(r_asq[s][ch]) * CubeProdW'(w_cb[ch])) >> 20);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_aval[s] <= 1'b0;
                r_bval[s] <= 1'b0;
            end else begin
                r_aval[s] <= w_val[s];
                r_bval[s] <= r_aval[s];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int ch = 0; ch < ChN; ch++) begin
                r_asq[s][ch]   <= w_sq[ch];
                r_aroot[s][ch] <= w_root[s][ch];
                r_av[s][ch]    <= w_v[s][ch];
                r_bv[s][ch]    <= r_av[s][ch];
                r_broot[s][ch] <= (w_cube[ch] <= CubeW'(r_av[s][ch])) ? w_cb[ch]
                                                                       : r_aroot[s][ch];
            end
        end
    end

    logic             r_l1val, r_l2val, r_l3val;
    t_v               r_l1v    [ChN];
    t_v               r_l2v    [ChN];
    t_f               r_l1root [ChN];
    t_f               r_l2root [ChN];
    logic [LinNW-1:0] r_l1n    [ChN];
    logic [LinPW-1:0] r_l2p    [ChN];
    t_f               r_l3f    [ChN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1val <= 1'b0;
            r_l2val <= 1'b0;
            r_l3val <= 1'b0;
        end else begin
            r_l1val <= w_val[CbrtSteps];
            r_l2val <= r_l1val;
            r_l3val <= r_l2val;
        end
    end

    // linear segment only matters for small v, so the low bits suffice
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < ChN; ch++) begin
            r_l1v[ch]    <= w_v[CbrtSteps][ch];
            r_l1root[ch] <= w_root[CbrtSteps][ch];
            r_l1n[ch]    <= LinNW'(w_v[CbrtSteps][ch][13:0]) * LinNW'(7787) + LinNW'(500);
            r_l2v[ch]    <= r_l1v[ch];
            r_l2root[ch] <= r_l1root[ch];
            r_l2p[ch]    <= LinPW'(r_l1n[ch]) * Recip1k;
            r_l3f[ch]    <= (r_l2v[ch] > LinCut) ? r_l2root[ch]
                                                 : FW'(r_l2p[ch] >> 37) + FOffset;
        end
    end

    assign o_valid = r_l3val;
    assign o_f     = r_l3f;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sRGB to CIE LCh pixel core.
`timescale 1ns / 1ps

module testbench;
    import s2lch_pkg::*;

    typedef struct {
        logic [14:0]        lightness;
        logic [15:0]        chroma;
        logic signed [15:0] hue;
    } t_lch;

    localparam int StallLimit = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    t_code              i_red_channel;
    t_code              i_green_channel;
    t_code              i_blue_channel;
    logic               o_done;
    logic [14:0]        o_lightness;
    logic [15:0]        o_chroma;
    logic signed [15:0] o_hue_angle;

    t_lch lch_expected[$];
    int   mismatches   = 0;
    int   pixels_sent  = 0;
    int   pixels_seen  = 0;
    int   stall_cycles = 0;

    srgb_to_lch_pixel_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_red_channel   (i_red_channel),
        .i_green_channel (i_green_channel),
        .i_blue_channel  (i_blue_channel),
        .o_done          (o_done),
        .o_lightness     (o_lightness),
        .o_chroma        (o_chroma),
        .o_hue_angle     (o_hue_angle)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // truncated fifth power in Q.30
    function automatic logic [63:0] fifth_power(input logic [63:0] r);
        logic [63:0] sq;
        logic [63:0] quad;
        sq   = (r * r) >> 30;
        quad = (sq * sq) >> 30;
        return (quad * r) >> 30;
    endfunction

    // sRGB transfer curve, 8-bit code to linear Q.20
    function automatic logic [63:0] srgb_decode(input logic [63:0] code);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] root;
        logic [63:0] trial;
        if (code * 64'd100000 <= 64'd1031475) begin
            return (code * 64'd104857600 + 64'd164730) / 64'd329460;
        end
        t    = (((64'd1000 * code + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        s    = (t * t) >> 30;
        root = '0;
        for (int k = 30; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial <= (64'd1 << 30) && fifth_power(trial) <= s) begin
                root = trial;
            end
        end
        return (((s * root) >> 30) + 64'd512) >> 10;
    endfunction

    // CIELAB f: cube root above the knee, linear segment below
    function automatic longint lab_curve(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        if (v * 64'd1000000 > 64'd8856 * 64'd1048576) begin
            root = '0;
            for (int k = 21; k >= 0; k--) begin
                trial = root | (64'd1 << k);
                if ((((trial * trial) >> 20) * trial >> 20) <= v) begin
                    root = trial;
                end
            end
            return longint'(root);
        end
        return longint'((64'd7787 * v + 64'd500) / 64'd1000) + 144631;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint cordic_hue(input longint a, input longint b);
        longint atan_step [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2};
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint h;
        if (a == 0 && b == 0) return 0;
        x = a;
        y = b;
        z = 0;
        // left half plane: rotate by pi first
        if (a < 0) begin
            x = -a;
            y = -b;
            z = (b >= 0) ? 205887 : -205887;
        end
        for (int k = 0; k < 16; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step[k];
            end
        end
        h = (z + 4) >>> 3;
        if (h > 25736) h = 25736;
        if (h < -25736) h = -25736;
        return h;
    endfunction

    function automatic t_lch pixel_to_lch(input t_code r, input t_code g, input t_code bl);
        logic [63:0] lr;
        logic [63:0] lg;
        logic [63:0] lb;
        logic [63:0] xn;
        logic [63:0] yn;
        logic [63:0] zn;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] c;
        longint      fx;
        longint      fy;
        longint      fz;
        longint      l;
        longint      a;
        longint      b;
        t_lch        res;
        lr = srgb_decode(64'(r));
        lg = srgb_decode(64'(g));
        lb = srgb_decode(64'(bl));
        xn = (64'd41239080 * lr + 64'd35758434 * lg + 64'd18048079 * lb + 64'd47524450)
             / 64'd95048900;
        yn = (64'd21263901 * lr + 64'd71516868 * lg + 64'd7219232 * lb + 64'd50000000)
             / 64'd100000000;
        zn = (64'd1933082 * lr + 64'd11919478 * lg + 64'd95053215 * lb + 64'd54442000)
             / 64'd108884000;
        fx = lab_curve(xn);
        fy = lab_curve(yn);
        fz = lab_curve(zn);
        l  = (116 * fy - (longint'(16) << 20) + 2048) >>> 12;
        a  = 500 * (fx - fy);
        b  = 200 * (fy - fz);
        ua = 64'(a < 0 ? -a : a);
        ub = 64'(b < 0 ? -b : b);
        c  = (int_sqrt(ua * ua + ub * ub) + 64'd2048) >> 12;
        if (l < 0) l = 0;
        if (l > 25600) l = 25600;
        if (c > 64'd65535) c = 64'd65535;
        res.lightness = l[14:0];
        res.chroma    = c[15:0];
        res.hue       = 16'(cordic_hue(a, b));
        return res;
    endfunction

    // drive one pixel and hold it until the core takes the beat
    task automatic send_pixel(input t_code r, input t_code g, input t_code b);
        i_start         <= 1'b1;
        i_red_channel   <= r;
        i_green_channel <= g;
        i_blue_channel  <= b;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        lch_expected.push_back(pixel_to_lch(r, g, b));
        pixels_sent++;
    endtask

    task automatic idle_burst();
        i_start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (lch_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);       // black, zero vector
        send_pixel(8'd255, 8'd255, 8'd255); // white, lightness at top
        send_pixel(8'd1, 8'd1, 8'd1);       // tiny gray, low lightness
        send_pixel(8'd10, 8'd10, 8'd10);    // last code on the linear segment
        send_pixel(8'd11, 8'd11, 8'd11);    // first code on the power curve
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);     // left half plane, b positive
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);   // left half plane, b negative
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'd85, 8'd170, 8'd85);
        send_pixel(8'd254, 8'd1, 8'd254);
    endtask

    task automatic test_pause();
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        drain();
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_random(input int count, input bit with_gaps);
        for (int n = 0; n < count; n++) begin
            if (with_gaps && $urandom_range(0, 4) == 0) idle_burst();
            case ($urandom_range(0, 4))
                0: begin
                    // near-gray pixels stress the zero vector and small chroma
                    t_code base;
                    base = 8'($urandom);
                    send_pixel(base, base + 8'($urandom_range(0, 1)), base);
                end
                1: send_pixel(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                              8'($urandom_range(0, 15)));
                default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_lch want;
        if (i_rst_n && o_done) begin
            pixels_seen++;
            if (lch_expected.size() == 0) begin
                $error("result with no pixel pending");
                mismatches++;
            end else begin
                want = lch_expected.pop_front();
                if (o_lightness !== want.lightness) begin
                    $error("lightness: expected %0d, got %0d", want.lightness, o_lightness);
                    mismatches++;
                end
                if (o_chroma !== want.chroma) begin
                    $error("chroma: expected %0d, got %0d", want.chroma, o_chroma);
                    mismatches++;
                end
                if (o_hue_angle !== want.hue) begin
                    $error("hue_angle: expected %0d, got %0d", want.hue, o_hue_angle);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: count cycles where no beat moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_red_channel   <= '0;
        i_green_channel <= '0;
        i_blue_channel  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pause();
        test_random(1200, 1'b1);
        test_random(300, 1'b0);
        drain();
        repeat (Latency + 10) @(posedge i_clk);

        $display("Covered %0d pixels (%0d results): extremes, primaries, gamma knee,",
                 pixels_sent, pixels_seen);
        $display("hue quadrants and random traffic with input gaps and a full drain.");
        if (mismatches == 0 && lch_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
